### hdl/pdc_pkg.sv
package pdc_pkg;

  localparam int SAMPLE_COUNT_DEF = 5;
  localparam int SUM_W            = 12;
  localparam int RECIP_SHIFT      = 28;

  localparam logic [7:0] MARGIN_RST      = 8'd15;
  localparam logic [7:0] MAX_AVERAGE_RST = 8'd140;
  localparam logic [7:0] DEFAULT_THR_RST = 8'd180;
  localparam logic [7:0] SAT_MAX         = 8'd255;

  typedef enum logic [1:0] {
    CMD_DETECT  = 2'd0,
    CMD_CAL     = 2'd1,
    CMD_SET     = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_MARGIN      = 2'd0,
    CFG_MAX_AVERAGE = 2'd1,
    CFG_DEFAULT_THR = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] margin;
    logic [7:0] max_average;
    logic [7:0] default_threshold;
  } cfg_t;

  typedef struct packed {
    logic             report_valid;
    logic             far;
    logic             cal_done;
    logic [SUM_W-1:0] trimmed;
    logic [7:0]       threshold_now;
  } mid_t;

endpackage

### hdl/pdc_core.sv
module pdc_core #(
  parameter int SAMPLE_COUNT = pdc_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_sample,
  input  logic signed [8:0]   in_offset_value,
  input  pdc_pkg::cfg_t       cfg,
  output logic                mid_valid,
  input  logic                mid_ready,
  output pdc_pkg::mid_t       mid
);

  localparam int CntW = $clog2(SAMPLE_COUNT);
  localparam logic [CntW-1:0] CntLast = CntW'(SAMPLE_COUNT - 1);

  // input register
  logic                 inp_vld_r, inp_vld_nxt;
  pdc_pkg::cmd_t        cmd_r;
  logic [7:0]           smp_r;
  logic signed [8:0]    off_r;

  // block state
  logic [7:0]                 thr_r, thr_nxt;
  logic [1:0]                 last_dist_r, last_dist_nxt;  // bit 1 valid, bit 0 far
  logic [pdc_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [7:0]                 min_r, min_nxt;
  logic [7:0]                 max_r, max_nxt;
  logic [CntW-1:0]            cnt_r, cnt_nxt;

  logic                 mid_vld_r, mid_vld_nxt;
  pdc_pkg::mid_t        mid_r, mid_nxt;

  logic                       mid_load;
  logic                       far_now;
  logic [pdc_pkg::SUM_W-1:0]  sum_add;
  logic [7:0]                 min_new;
  logic [7:0]                 max_new;
  logic [8:0]                 thr_sum;
  logic [7:0]                 thr_sat;

  assign mid_load  = inp_vld_r && (!mid_vld_r || mid_ready);
  assign in_ready  = !inp_vld_r || mid_load;
  assign mid_valid = mid_vld_r;
  assign mid       = mid_r;

  assign far_now = !(smp_r > thr_r);
  assign sum_add = sum_r + pdc_pkg::SUM_W'(smp_r);
  assign min_new = (smp_r < min_r) ? smp_r : min_r;
  assign max_new = (smp_r > max_r) ? smp_r : max_r;
  assign thr_sum = {1'b0, off_r[7:0]} + {1'b0, cfg.margin};
  assign thr_sat = thr_sum[8] ? pdc_pkg::SAT_MAX : thr_sum[7:0];

  always_comb begin
    inp_vld_nxt = inp_vld_r;
    if (mid_load) begin
      inp_vld_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      inp_vld_nxt = 1'b1;
    end
  end

  always_comb begin
    mid_vld_nxt = mid_vld_r;
    if (mid_load) begin
      mid_vld_nxt = 1'b1;
    end else if (mid_ready) begin
      mid_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    thr_nxt       = thr_r;
    last_dist_nxt = last_dist_r;
    sum_nxt       = sum_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    cnt_nxt       = cnt_r;
    mid_nxt       = '0;
    case (cmd_r)
      pdc_pkg::CMD_DETECT: begin
        mid_nxt.far          = far_now;
        mid_nxt.report_valid = (last_dist_r != {1'b1, far_now});
        last_dist_nxt        = {1'b1, far_now};
      end
      pdc_pkg::CMD_CAL: begin
        if (cnt_r == CntLast) begin
          mid_nxt.cal_done = 1'b1;
          mid_nxt.trimmed  = sum_add - pdc_pkg::SUM_W'(min_new) - pdc_pkg::SUM_W'(max_new);
          sum_nxt          = '0;
          min_nxt          = pdc_pkg::SAT_MAX;
          max_nxt          = '0;
          cnt_nxt          = '0;
        end else begin
          sum_nxt = sum_add;
          min_nxt = min_new;
          max_nxt = max_new;
          cnt_nxt = cnt_r + CntW'(1);
        end
      end
      pdc_pkg::CMD_SET: begin
        if (off_r[8]) begin
          thr_nxt = cfg.default_threshold;
        end else if (off_r[7:0] > cfg.max_average) begin
          thr_nxt = pdc_pkg::SAT_MAX;
        end else begin
          thr_nxt = thr_sat;
        end
      end
      pdc_pkg::CMD_RESTART: begin
        last_dist_nxt = '0;
        sum_nxt       = '0;
        min_nxt       = pdc_pkg::SAT_MAX;
        max_nxt       = '0;
        cnt_nxt       = '0;
      end
      default: begin
        last_dist_nxt = last_dist_r;
      end
    endcase
    mid_nxt.threshold_now = thr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inp_vld_r   <= 1'b0;
      mid_vld_r   <= 1'b0;
      thr_r       <= pdc_pkg::DEFAULT_THR_RST;
      last_dist_r <= '0;
      sum_r       <= '0;
      min_r       <= pdc_pkg::SAT_MAX;
      max_r       <= '0;
      cnt_r       <= '0;
    end else begin
      inp_vld_r <= inp_vld_nxt;
      mid_vld_r <= mid_vld_nxt;
      if (mid_load) begin
        thr_r       <= thr_nxt;
        last_dist_r <= last_dist_nxt;
        sum_r       <= sum_nxt;
        min_r       <= min_nxt;
        max_r       <= max_nxt;
        cnt_r       <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= pdc_pkg::cmd_t'(in_command);
      smp_r <= in_sample;
      off_r <= in_offset_value;
    end
    if (mid_load) begin
      mid_r <= mid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntLast)
    else $error("calibration count past last sample");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    mid_load && (cmd_r == pdc_pkg::CMD_RESTART) |=> (last_dist_r == 2'b00) && (cnt_r == '0))
    else $error("restart did not clear progress");

  a_cal_fields: assert property (@(posedge clk) disable iff (!rst_n)
    mid_vld_r && mid_r.cal_done |-> !mid_r.report_valid && !mid_r.far)
    else $error("calibration result carries detect fields");
`endif

endmodule

### hdl/pdc_div.sv
module pdc_div #(
  parameter int SAMPLE_COUNT = pdc_pkg::SAMPLE_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           mid_valid,
  output logic           mid_ready,
  input  pdc_pkg::mid_t  mid,
  input  logic [7:0]     max_average,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_report_valid,
  output logic           out_far,
  output logic           out_cal_done,
  output logic [7:0]     out_cal_average,
  output logic           out_cal_over_max,
  output logic [7:0]     out_threshold_now
);

  localparam int Divisor = SAMPLE_COUNT - 2;
  localparam int RecipW  = pdc_pkg::RECIP_SHIFT + 1;
  localparam int ProdW   = pdc_pkg::SUM_W + RecipW;
  localparam int QuoW    = ProdW - pdc_pkg::RECIP_SHIFT;
  // ceil(2^shift / divisor): exact quotient for every trimmed sum
  localparam logic [RecipW-1:0] RecipM =
    RecipW'(((64'd1 << pdc_pkg::RECIP_SHIFT) + 64'(Divisor) - 64'd1) / 64'(Divisor));

  logic              out_vld_r, out_vld_nxt;
  logic              load;
  logic [ProdW-1:0]  prod;
  logic [QuoW-1:0]   quo;
  logic [7:0]        avg;

  assign mid_ready = !out_vld_r || out_ready;
  assign load      = mid_valid && mid_ready;
  assign out_valid = out_vld_r;

  assign prod = ProdW'(mid.trimmed) * ProdW'(RecipM);
  assign quo  = prod[ProdW-1:pdc_pkg::RECIP_SHIFT];
  assign avg  = (quo > QuoW'(pdc_pkg::SAT_MAX)) ? pdc_pkg::SAT_MAX : quo[7:0];

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_report_valid  <= mid.report_valid;
      out_far           <= mid.far;
      out_cal_done      <= mid.cal_done;
      out_cal_average   <= mid.cal_done ? avg : 8'd0;
      out_cal_over_max  <= mid.cal_done && (avg > max_average);
      out_threshold_now <= mid.threshold_now;
    end
  end

`ifndef SYNTHESIS
  a_over_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_cal_over_max |-> out_cal_done)
    else $error("over-maximum flag without finished calibration");
`endif

endmodule

### hdl/proximity_detect_calibrate_top.sv
// Proximity threshold detector with trimmed-mean calibration.
// Input channel (in_valid/in_ready): command, 8-bit sample, signed 9-bit
// offset_value. Every transaction gives exactly one result transaction on
// out_valid/out_ready: detect report and far flag, calibration done with
// trimmed mean and over-maximum flag, and the threshold in force after it.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes margin (0),
// max_average (1) and default_threshold (2); other indexes are dropped.
// cfg_ready is always high; write only while no transaction is in flight.
// Data passes the input register, the state update stage and the
// reciprocal-multiply divide stage feeding the result register.
// Throughput: one transaction per cycle while out_ready is high; every stage
// refills in the cycle it drains.
// When out_ready is low, the result register holds, the stages behind it
// fill up and in_ready drops once all three are occupied.
// Reset (rst_n low, synchronous): threshold 180, registers to 15/140/180,
// no previous distance, calibration progress cleared, pipeline empty.
module proximity_detect_calibrate_top #(
  parameter int SAMPLE_COUNT = pdc_pkg::SAMPLE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_sample,
  input  logic signed [8:0]  in_offset_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_report_valid,
  output logic               out_far,
  output logic               out_cal_done,
  output logic [7:0]         out_cal_average,
  output logic               out_cal_over_max,
  output logic [7:0]         out_threshold_now,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  pdc_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           mid_valid;
  logic           mid_ready;
  pdc_pkg::mid_t  mid;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (pdc_pkg::cfg_idx_t'(cfg_index))
        pdc_pkg::CFG_MARGIN:      cfg_nxt.margin            = cfg_data;
        pdc_pkg::CFG_MAX_AVERAGE: cfg_nxt.max_average       = cfg_data;
        pdc_pkg::CFG_DEFAULT_THR: cfg_nxt.default_threshold = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.margin            <= pdc_pkg::MARGIN_RST;
      cfg_r.max_average       <= pdc_pkg::MAX_AVERAGE_RST;
      cfg_r.default_threshold <= pdc_pkg::DEFAULT_THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pdc_core #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_sample       (in_sample),
    .in_offset_value (in_offset_value),
    .cfg             (cfg_r),
    .mid_valid       (mid_valid),
    .mid_ready       (mid_ready),
    .mid             (mid)
  );

  pdc_div #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_div (
    .clk               (clk),
    .rst_n             (rst_n),
    .mid_valid         (mid_valid),
    .mid_ready         (mid_ready),
    .mid               (mid),
    .max_average       (cfg_r.max_average),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_report_valid  (out_report_valid),
    .out_far           (out_far),
    .out_cal_done      (out_cal_done),
    .out_cal_average   (out_cal_average),
    .out_cal_over_max  (out_cal_over_max),
    .out_threshold_now (out_threshold_now)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

localparam int SAMPLES = pdc_pkg::SAMPLE_COUNT_DEF;
localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index, write is dropped

typedef struct packed {
  bit       report_valid;
  bit       far;
  bit       cal_done;
  bit [7:0] cal_average;
  bit       cal_over_max;
  bit [7:0] threshold_now;
} prox_result_t;

class proximity_scoreboard;
  bit [7:0]  margin;
  bit [7:0]  max_avg;
  bit [7:0]  dflt_thr;
  bit [7:0]  near_thr;
  bit        have_last;
  bit        last_far;
  bit [11:0] cal_sum;
  bit [7:0]  cal_min;
  bit [7:0]  cal_max;
  bit [3:0]  cal_count;
  prox_result_t expected_q[$];
  int mismatches;
  int n_detect, n_reports, n_cal_done, n_over, n_set, n_restart, n_checked;

  function new();
    margin = pdc_pkg::MARGIN_RST;
    max_avg = pdc_pkg::MAX_AVERAGE_RST;
    dflt_thr = pdc_pkg::DEFAULT_THR_RST;
    near_thr = pdc_pkg::DEFAULT_THR_RST;
    have_last = 1'b0;
    last_far = 1'b0;
    clear_cal();
    mismatches = 0;
    n_detect = 0; n_reports = 0; n_cal_done = 0; n_over = 0;
    n_set = 0; n_restart = 0; n_checked = 0;
  endfunction

  function void clear_cal();
    cal_sum = '0;
    cal_min = 8'd255;
    cal_max = 8'd0;
    cal_count = '0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [7:0] data);
    case (idx)
      pdc_pkg::CFG_MARGIN:      margin = data;
      pdc_pkg::CFG_MAX_AVERAGE: max_avg = data;
      pdc_pkg::CFG_DEFAULT_THR: dflt_thr = data;
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function int threshold();
    return int'(near_thr);
  endfunction

  // Advance the predicted state by one accepted transaction.
  function void note_input(pdc_pkg::cmd_t cmd, logic [7:0] smp, logic signed [8:0] ofs);
    prox_result_t r;
    bit [8:0]     sum9;
    bit [11:0]    trimmed;
    int unsigned  avg;
    r = '0;
    case (cmd)
      pdc_pkg::CMD_DETECT: begin
        r.far = (smp > near_thr) ? 1'b0 : 1'b1;
        r.report_valid = !have_last || (last_far != r.far);
        have_last = 1'b1;
        last_far = r.far;
        n_detect++;
        if (r.report_valid) n_reports++;
      end
      pdc_pkg::CMD_CAL: begin
        cal_sum = cal_sum + 12'(smp);
        if (smp < cal_min) cal_min = smp;
        if (smp > cal_max) cal_max = smp;
        if (cal_count + 1 >= SAMPLES) begin
          trimmed = cal_sum - 12'(cal_min) - 12'(cal_max);
          avg = 32'(trimmed) / 32'(SAMPLES - 2);
          if (avg > 255) avg = 255;
          r.cal_done = 1'b1;
          r.cal_average = avg[7:0];
          r.cal_over_max = (avg > max_avg);
          n_cal_done++;
          if (r.cal_over_max) n_over++;
          clear_cal();
        end else begin
          cal_count = cal_count + 4'd1;
        end
      end
      pdc_pkg::CMD_SET: begin
        n_set++;
        if (ofs[8]) begin
          near_thr = dflt_thr;
        end else if (ofs[7:0] > max_avg) begin
          near_thr = 8'd255;
        end else begin
          sum9 = {1'b0, ofs[7:0]} + {1'b0, margin};
          near_thr = sum9[8] ? 8'd255 : sum9[7:0];
        end
      end
      default: begin
        n_restart++;
        have_last = 1'b0;
        clear_cal();
      end
    endcase
    r.threshold_now = near_thr;
    expected_q.push_back(r);
  endfunction

  function void check_result(prox_result_t got);
    prox_result_t exp_r;
    bit bad;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing expected: rv=%0d far=%0d done=%0d",
                 $time, got.report_valid, got.far, got.cal_done,
                 " avg=%0d over=%0d thr=%0d",
                 got.cal_average, got.cal_over_max, got.threshold_now);
      return;
    end
    exp_r = expected_q.pop_front();
    n_checked++;
    bad = 1'b0;
    if (got.report_valid != exp_r.report_valid) bad = 1'b1;
    if (got.far != exp_r.far) bad = 1'b1;
    if (got.cal_done != exp_r.cal_done) bad = 1'b1;
    if (got.cal_average != exp_r.cal_average) bad = 1'b1;
    if (got.cal_over_max != exp_r.cal_over_max) bad = 1'b1;
    if (got.threshold_now != exp_r.threshold_now) bad = 1'b1;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch on result %0d", $time, n_checked);
        $display("  expected rv=%0d far=%0d done=%0d avg=%0d over=%0d thr=%0d",
                 exp_r.report_valid, exp_r.far, exp_r.cal_done, exp_r.cal_average,
                 exp_r.cal_over_max, exp_r.threshold_now);
        $display("  actual   rv=%0d far=%0d done=%0d avg=%0d over=%0d thr=%0d",
                 got.report_valid, got.far, got.cal_done, got.cal_average,
                 got.cal_over_max, got.threshold_now);
      end
    end
  endfunction
endclass

module testbench;

  localparam int LATENCY     = 3;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 115;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_command;
  logic [7:0]        in_sample;
  logic signed [8:0] in_offset_value;
  logic              out_valid;
  logic              out_ready;
  logic              out_report_valid;
  logic              out_far;
  logic              out_cal_done;
  logic [7:0]        out_cal_average;
  logic              out_cal_over_max;
  logic [7:0]        out_threshold_now;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [7:0]        cfg_data;

  proximity_scoreboard sb;
  bit quiet   = 1'b0;
  bit rx_hold = 1'b0;
  int n_sent  = 0;
  int n_blocked = 0;

  proximity_detect_calibrate_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_sample         (in_sample),
    .in_offset_value   (in_offset_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_report_valid  (out_report_valid),
    .out_far           (out_far),
    .out_cal_done      (out_cal_done),
    .out_cal_average   (out_cal_average),
    .out_cal_over_max  (out_cal_over_max),
    .out_threshold_now (out_threshold_now),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] clamp8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic logic signed [8:0] rand_offset();
    return 9'($urandom_range(0, 511));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input pdc_pkg::cmd_t cmd, input logic [7:0] smp,
                           input logic signed [8:0] ofs);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sample <= smp;
    in_offset_value <= ofs;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, smp, ofs);
    n_sent++;
  endtask

  // Drop valid and let the pipeline drain completely.
  task automatic wait_idle();
    int cnt;
    cnt = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && cnt < 5000) begin
      @(posedge clk);
      cnt++;
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(input logic [7:0] m, input logic [7:0] ma,
                                input logic [7:0] dt);
    write_reg(pdc_pkg::CFG_DEFAULT_THR, dt);
    write_reg(CFG_SPARE, rand_byte());
    write_reg(pdc_pkg::CFG_MARGIN, m);
    write_reg(pdc_pkg::CFG_MAX_AVERAGE, ma);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int            sent_here, kind, len, d, base, spread;
    pdc_pkg::cmd_t c;
    sent_here = 0;
    while (sent_here < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 38) begin
        // run of detections, half of them hugging the threshold
        len = $urandom_range(1, 8);
        repeat (len) begin
          d = $urandom_range(0, 4);
          if ($urandom_range(0, 1))
            send_item(pdc_pkg::CMD_DETECT, clamp8(sb.threshold() + d - 2), rand_offset());
          else
            send_item(pdc_pkg::CMD_DETECT, rand_byte(), rand_offset());
        end
        sent_here += len;
      end else if (kind < 68) begin
        // complete calibration set, clustered or spread wide
        base = $urandom_range(0, 255);
        spread = $urandom_range(0, 1) ? 8 : 255;
        repeat (SAMPLES) begin
          d = $urandom_range(0, 2 * spread);
          send_item(pdc_pkg::CMD_CAL, clamp8(base + d - spread), rand_offset());
        end
        sent_here += SAMPLES;
      end else if (kind < 82) begin
        case ($urandom_range(0, 2))
          0: d = -$urandom_range(1, 256);
          1: d = sb.max_avg + $urandom_range(0, 4) - 2;
          default: d = $urandom_range(0, 255);
        endcase
        if (d > 255) d = 255;
        send_item(pdc_pkg::CMD_SET, rand_byte(), 9'(d));
        sent_here++;
      end else if (kind < 87) begin
        send_item(pdc_pkg::CMD_RESTART, rand_byte(), rand_offset());
        sent_here++;
      end else begin
        // noise: any command, any fields, breaks calibration sets apart
        len = $urandom_range(1, 4);
        repeat (len) begin
          c = pdc_pkg::cmd_t'(2'($urandom_range(0, 3)));
          send_item(c, rand_byte(), rand_offset());
        end
        sent_here += len;
      end
    end
  endtask

  // Result side: check each transaction, stall in random bursts.
  initial begin
    int stall;
    prox_result_t got;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (in_valid && !in_ready) n_blocked++;
      if (rst_n && out_valid && out_ready) begin
        got.report_valid = out_report_valid;
        got.far = out_far;
        got.cal_done = out_cal_done;
        got.cal_average = out_cal_average;
        got.cal_over_max = out_cal_over_max;
        got.threshold_now = out_threshold_now;
        sb.check_result(got);
      end
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 17);
      out_ready <= (stall == 0) && !rx_hold;
    end
  end

  // Long receiver hold-off while the sender keeps offering transactions.
  initial begin
    wait (n_sent >= 150);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int p;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= pdc_pkg::CMD_DETECT;
    in_sample <= '0;
    in_offset_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= pdc_pkg::CFG_MARGIN;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: threshold 180, margin 15, max 140.
    send_item(pdc_pkg::CMD_DETECT, 8'd255, 9'sd0);    // near, first result reports
    send_item(pdc_pkg::CMD_DETECT, 8'd0, -9'sd1);     // far
    send_item(pdc_pkg::CMD_DETECT, 8'd0, 9'sd255);    // far again, no report
    send_item(pdc_pkg::CMD_DETECT, 8'd180, 9'sd0);    // equal to threshold is far
    send_item(pdc_pkg::CMD_DETECT, 8'd181, 9'sd0);    // just above is near
    send_item(pdc_pkg::CMD_CAL, 8'd0, 9'sd0);
    send_item(pdc_pkg::CMD_CAL, 8'd255, 9'sd0);
    send_item(pdc_pkg::CMD_CAL, 8'd100, 9'sd0);
    send_item(pdc_pkg::CMD_CAL, 8'd200, 9'sd0);
    send_item(pdc_pkg::CMD_CAL, 8'd50, 9'sd0);        // set done, min and max dropped
    send_item(pdc_pkg::CMD_CAL, 8'd10, 9'sd0);
    send_item(pdc_pkg::CMD_CAL, 8'd20, 9'sd0);
    send_item(pdc_pkg::CMD_RESTART, 8'd255, 9'sh100); // abandon partial set
    repeat (SAMPLES) send_item(pdc_pkg::CMD_CAL, 8'd255, 9'sd0); // mean above maximum
    send_item(pdc_pkg::CMD_SET, 8'd0, -9'sd1);        // negative: default threshold
    send_item(pdc_pkg::CMD_SET, 8'd0, 9'sd141);       // above maximum: 255
    send_item(pdc_pkg::CMD_SET, 8'd0, 9'sd140);
    send_item(pdc_pkg::CMD_SET, 8'd0, 9'sh100);
    send_item(pdc_pkg::CMD_SET, 8'd0, 9'sd0);
    send_item(pdc_pkg::CMD_DETECT, 8'd0, 9'sd0);      // first detect after restart reports
    send_item(pdc_pkg::CMD_SET, 8'd0, 9'sd255);
    wait_idle();

    for (p = 0; p < 5; p++) begin
      case (p)
        0: apply_settings(8'd0, 8'd0, 8'd0);
        1: apply_settings(8'd255, 8'd255, 8'd255);
        2: apply_settings(8'd100, 8'd250, 8'd60);
        3: apply_settings(rand_byte(), rand_byte(), rand_byte());
        default: apply_settings(pdc_pkg::MARGIN_RST, pdc_pkg::MAX_AVERAGE_RST,
                                pdc_pkg::DEFAULT_THR_RST);
      endcase
      quiet = (p == 4);
      run_random(PHASE_ITEMS);
      wait_idle();
    end

    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    $display("sent %0d transactions: %0d detections (%0d reports), %0d sets, %0d restarts",
             n_sent, sb.n_detect, sb.n_reports, sb.n_set, sb.n_restart);
    $display("%0d calibrations (%0d over max), input blocked %0d cycles, %0d mismatches",
             sb.n_cal_done, sb.n_over, n_blocked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/pdc_pkg.sv
hdl/pdc_core.sv
hdl/pdc_div.sv
hdl/proximity_detect_calibrate_top.sv
tb/testbench.sv
